// File: rtl/core/htw_pkg.sv
// Package: types, constants and helpers for the hierarchical timer wheel.
`timescale 1ns / 1ps
package htw_pkg;

  localparam int WheelBitsDef = 8;
  localparam int NumTimersDef = 32;
  localparam int TickBitsDef  = 48;
  localparam int IdW          = $clog2(NumTimersDef);
  localparam int TickW        = TickBitsDef;
  localparam int CntW         = $clog2(NumTimersDef) + 1;

  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_ENABLE  = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;
  localparam logic [1:0] MODE_TICK    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_NOENTRY = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IdW-1:0]   timer_id;
    logic [TickW-1:0] due_tick;
    logic [TickW-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            expired_valid;
    logic [IdW-1:0]  expired_timer;
    logic [CntW-1:0] expired_count;
    logic            last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic restart;    // clear table, set wheel tick
    logic enable;     // place addressed timer
    logic remove;     // remove addressed timer
    logic scan_start; // reset scan pointer for a pass
    logic scan_step;  // process entry at pointer
    logic [1:0] pass; // 1..3 cascade level, 0 expiry pass
    logic advance;    // wheel tick + 1
    logic emit_last;  // result is final
  } htw_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       tick_due;   // wheel tick <= now
    logic       low_zero;   // level 0 digit is zero
    logic       l1_zero;    // level 1 digit is zero
    logic       l2_zero;    // level 2 digit is zero
    logic       scan_end;   // pointer at last entry
    logic       hit;        // expiry hit at pointer
    logic       any_hit;    // at least one expiry found
  } htw_stat_t;

endpackage

// File: rtl/core/hierarchical_timer_wheel_top.sv
// Top level of the four-level hierarchical timer wheel.
// Usage:
//  - in channel (in_valid_i/in_ready_o, in_item_i) takes one command item:
//    restart, enable timer, remove timer or tick.
//  - out channel (out_valid_o/out_ready_i, out_item_o) returns results;
//    last marks the final result of a command.
//  - restart/enable/remove: one result per item.
//  - tick: when the low digit is zero, a cascade pass over all NUM_TIMERS
//    entries per cascaded level (up to three) and an advance step, then an
//    expiry pass over all entries and one closing result step. The table
//    scan visits one entry per cycle, unless the receiver stalls the expiry pass.
//  - expired timers leave in ascending id order, at most one per cycle; the
//    latest is held until the scan ends so the final one carries the count
//    and last. A tick with no expiry gives one empty result.
//  - a stalled receiver holds the expiry scan at its current entry.
//  - reset clears all enabled/placed flags and sets the wheel tick to one;
//    timer due, level and slot are written on enable.
`timescale 1ns / 1ps
module hierarchical_timer_wheel_top #(
  parameter int WHEEL_BITS = htw_pkg::WheelBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  htw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output htw_pkg::out_item_t out_item_o
);
  import htw_pkg::*;

  htw_cmd_t  cmd;
  htw_stat_t stat;
  out_item_t res;

  htw_datapath #(
    .WHEEL_BITS(WHEEL_BITS)
  ) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_item_i),
    .cmd_i(cmd), .stat_o(stat), .res_o(res)
  );

  htw_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .res_i(res), .out_o(out_item_o), .stat_i(stat), .cmd_o(cmd)
  );

endmodule

// File: rtl/core/htw_datapath.sv
// Datapath: timer table, wheel tick, placement and scan logic.
`timescale 1ns / 1ps
module htw_datapath #(
  parameter int WHEEL_BITS = htw_pkg::WheelBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htw_pkg::in_item_t   in_i,
  input  htw_pkg::htw_cmd_t   cmd_i,
  output htw_pkg::htw_stat_t  stat_o,
  output htw_pkg::out_item_t  res_o
);
  import htw_pkg::*;

  localparam int NUM_TIMERS = NumTimersDef;
  localparam int TICK_BITS  = TickBitsDef;
  localparam int PtrW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SlotW = WHEEL_BITS;

  logic [TICK_BITS-1:0] wheel_q, wheel_d;
  logic [TICK_BITS-1:0] due_q [NUM_TIMERS];
  logic [1:0]           lvl_q [NUM_TIMERS];
  logic [SlotW-1:0]     slot_q[NUM_TIMERS];
  logic [NUM_TIMERS-1:0] en_q, pl_q;
  in_item_t             it_q;
  logic [PtrW-1:0]      ptr_q;
  logic [CntW-1:0]      cnt_q;

  logic [TICK_BITS-1:0] now_w, due_in_w;
  logic                 id_ok;
  logic [PtrW-1:0]      id_w;

  assign now_w    = it_q.now_tick[TICK_BITS-1:0];
  assign due_in_w = it_q.due_tick[TICK_BITS-1:0];
  assign id_ok    = ({{(32-IdW){1'b0}}, it_q.timer_id} < NUM_TIMERS);
  assign id_w     = it_q.timer_id[PtrW-1:0];

  // placement of one due time against the wheel tick
  typedef struct packed {
    logic [TICK_BITS-1:0] due;
    logic [1:0]           lvl;
    logic [SlotW-1:0]     slot;
  } place_t;

  function automatic place_t place(input logic [TICK_BITS-1:0] d_in,
                                   input logic [TICK_BITS-1:0] wt);
    place_t p;
    logic [TICK_BITS-1:0] d, gap, sd;
    d = (d_in < wt) ? wt : d_in;
    gap = d - wt;
    p.due = d;
    sd = d;
    if (gap < (TICK_BITS'(1) << WHEEL_BITS)) begin
      p.lvl = 2'd0;
      p.slot = sd[SlotW-1:0];
    end else if (gap < (TICK_BITS'(1) << (2*WHEEL_BITS))) begin
      p.lvl = 2'd1;
      p.slot = SlotW'(sd >> WHEEL_BITS);
    end else if (gap < (TICK_BITS'(1) << (3*WHEEL_BITS))) begin
      p.lvl = 2'd2;
      p.slot = SlotW'(sd >> (2*WHEEL_BITS));
    end else begin
      if (gap > TICK_BITS'(33'h0_ffff_ffff)) begin
        sd = wt + TICK_BITS'(33'h0_ffff_ffff);
      end
      p.lvl = 2'd3;
      p.slot = SlotW'(sd >> (3*WHEEL_BITS));
    end
    return p;
  endfunction

  place_t pl_en, pl_sc;
  logic [SlotW-1:0] pass_slot;
  logic             match;

  assign pl_en = place(due_in_w, wheel_q);
  assign pl_sc = place(due_q[ptr_q], wheel_q);

  always_comb begin
    case (cmd_i.pass)
      2'd1:    pass_slot = SlotW'(wheel_q >> WHEEL_BITS);
      2'd2:    pass_slot = SlotW'(wheel_q >> (2*WHEEL_BITS));
      2'd3:    pass_slot = SlotW'(wheel_q >> (3*WHEEL_BITS));
      default: pass_slot = wheel_q[SlotW-1:0] - SlotW'(1);  // old tick after advance
    endcase
  end

  assign match = pl_q[ptr_q] && (lvl_q[ptr_q] == cmd_i.pass) &&
                 (slot_q[ptr_q] == pass_slot);

  assign wheel_d = cmd_i.restart ? now_w + TICK_BITS'(1) : wheel_q + TICK_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= TICK_BITS'(1);
      en_q    <= '0;
      pl_q    <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.restart) begin
        en_q <= '0;
        pl_q <= '0;
      end
      if (cmd_i.restart || cmd_i.advance) wheel_q <= wheel_d;
      if (cmd_i.enable && id_ok && !en_q[id_w]) begin
        en_q[id_w] <= 1'b1;
        pl_q[id_w] <= 1'b1;
      end
      if (cmd_i.remove && id_ok && pl_q[id_w]) begin
        en_q[id_w] <= 1'b0;
        pl_q[id_w] <= 1'b0;
      end
      if (cmd_i.load) cnt_q <= '0;
      if (cmd_i.scan_start) ptr_q <= '0;
      else if (cmd_i.scan_step) ptr_q <= ptr_q + PtrW'(1);
      if (cmd_i.scan_step) begin
        if (match) begin
          if (cmd_i.pass == 2'd0) begin
            pl_q[ptr_q] <= 1'b0;
            en_q[ptr_q] <= 1'b0;
            if (en_q[ptr_q]) cnt_q <= cnt_q + CntW'(1);
          end else if (!en_q[ptr_q]) begin
            pl_q[ptr_q] <= 1'b0;
          end
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_i;
    if (cmd_i.enable && id_ok && !en_q[id_w]) begin
      due_q[id_w]  <= pl_en.due;
      lvl_q[id_w]  <= pl_en.lvl;
      slot_q[id_w] <= pl_en.slot;
    end
    if (cmd_i.scan_step && match && cmd_i.pass != 2'd0 && en_q[ptr_q]) begin
      due_q[ptr_q]  <= pl_sc.due;
      lvl_q[ptr_q]  <= pl_sc.lvl;
      slot_q[ptr_q] <= pl_sc.slot;
    end
  end

  assign stat_o.mode     = it_q.mode;
  assign stat_o.tick_due = (wheel_q <= now_w);
  assign stat_o.low_zero = (wheel_q[SlotW-1:0] == '0);
  assign stat_o.l1_zero  = (SlotW'(wheel_q >> WHEEL_BITS) == '0);
  assign stat_o.l2_zero  = (SlotW'(wheel_q >> (2*WHEEL_BITS)) == '0);
  assign stat_o.scan_end = ({{(32-PtrW){1'b0}}, ptr_q} == NUM_TIMERS - 1);
  assign stat_o.hit      = match && en_q[ptr_q] && (cmd_i.pass == 2'd0);
  assign stat_o.any_hit  = (cnt_q != '0);

  // result formed from the current command and table state
  always_comb begin
    res_o = '0;
    res_o.last = cmd_i.emit_last;
    case (it_q.mode)
      MODE_ENABLE: begin
        if (!id_ok) res_o.status = ST_NOENTRY;
        else if (en_q[id_w]) res_o.status = ST_BUSY;
      end
      MODE_REMOVE: begin
        if (!id_ok || !pl_q[id_w]) res_o.status = ST_NOENTRY;
      end
      MODE_TICK: begin
        if (cmd_i.scan_step) begin
          res_o.expired_valid = 1'b1;
          res_o.expired_timer = IdW'(ptr_q);
        end
        if (cmd_i.emit_last) res_o.expired_count = cnt_q;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/htw_ctrl.sv
// Controller: sequences commands, scan passes and result handshake.
`timescale 1ns / 1ps
module htw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  htw_pkg::out_item_t  res_i,
  output htw_pkg::out_item_t  out_o,
  input  htw_pkg::htw_stat_t  stat_i,
  output htw_pkg::htw_cmd_t   cmd_o
);
  import htw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CASC, S_EXP, S_WAIT, S_FINAL
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic       ov_q, ov_d;
  out_item_t  out_q, out_d;
  out_item_t  held_q, held_d;   // latest expiry, sent once the next is known

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    lvl_d   = lvl_q;
    ov_d    = ov_q && !out_ready_i;
    out_d   = out_q;
    held_d  = held_q;
    cmd_o.pass = lvl_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.emit_last = 1'b1;
        cmd_o.scan_start = 1'b1;
        case (stat_i.mode)
          MODE_RESTART: begin
            cmd_o.restart = 1'b1;
            out_d = res_i; ov_d = 1'b1; state_d = S_IDLE;
          end
          MODE_ENABLE: begin
            cmd_o.enable = 1'b1;
            out_d = res_i; ov_d = 1'b1; state_d = S_IDLE;
          end
          MODE_REMOVE: begin
            cmd_o.remove = 1'b1;
            out_d = res_i; ov_d = 1'b1; state_d = S_IDLE;
          end
          default: begin
            if (!stat_i.tick_due) begin
              out_d = res_i; ov_d = 1'b1; state_d = S_IDLE;
            end else if (stat_i.low_zero) begin
              cmd_o.emit_last = 1'b0;
              lvl_d = 2'd1; state_d = S_CASC;
            end else begin
              cmd_o.emit_last = 1'b0;
              cmd_o.advance = 1'b1;
              lvl_d = 2'd0; state_d = S_EXP;
            end
          end
        endcase
      end
      S_CASC: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.scan_start = 1'b1;
          if ((lvl_q == 2'd1 && stat_i.l1_zero) || (lvl_q == 2'd2 && stat_i.l2_zero)) begin
            lvl_d = lvl_q + 2'd1;
          end else begin
            cmd_o.scan_step = 1'b1;
            lvl_d = 2'd0;
            state_d = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // advance before the expiry pass
        cmd_o.advance = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d = S_EXP;
      end
      S_EXP: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.hit) begin
            // a newer hit releases the held one as a non-final result
            held_d = res_i;
            if (stat_i.any_hit) begin
              out_d = held_q;
              ov_d = 1'b1;
            end
          end
          if (stat_i.scan_end) state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.emit_last = 1'b1;
          out_d = res_i;
          out_d.expired_valid = 1'b0;
          out_d.expired_timer = '0;
          if (stat_i.any_hit) begin
            // last expiry carries the count and the last flag
            out_d.expired_valid = 1'b1;
            out_d.expired_timer = held_q.expired_timer;
          end
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= 2'd0;
      ov_q    <= 1'b0;
      out_q   <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      ov_q    <= ov_d;
      out_q   <= out_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: rtl/core/htw_checker.sv
// Port-level checker for the timer wheel, bound to the top level.
`timescale 1ns / 1ps
module htw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input htw_pkg::out_item_t out_item_o
);
  import htw_pkg::*;

  // no new item while a result waits
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  // expiry results report ok status
  a_exp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.expired_valid |-> out_item_o.status == ST_OK)
    else $error("expiry with error status");

  // count only on last
  a_cnt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.expired_count == '0)
    else $error("count on non-last result");

endmodule

bind hierarchical_timer_wheel_top htw_checker u_htw_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
);

// File: bench/hierarchical_timer_wheel_top_tb.sv
// Testbench for the hierarchical timer wheel: directed and random commands against a predictor.
`timescale 1ns / 1ps
module hierarchical_timer_wheel_top_tb;
  import htw_pkg::*;

  localparam int WB = WheelBitsDef;
  localparam int NT = NumTimersDef;
  localparam logic [63:0] FAR_DIST = 64'hffffffff;
  localparam logic [TickW-1:0] TICK_MAX = {TickW{1'b1}};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  hierarchical_timer_wheel_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the timer table.
  logic [TickW-1:0] wheel_now;
  logic [TickW-1:0] due_tbl [NT];
  logic             en_tbl  [NT];
  logic             pl_tbl  [NT];
  logic [1:0]       lvl_tbl [NT];
  logic [7:0]       slot_tbl[NT];

  out_item_t pending_results[$];
  int        errors = 0;
  bit        quiet = 1'b0;   // when set, both sides never idle

  // Place one timer on the level picked by its distance from the wheel tick.
  function automatic void place(int id);
    logic [TickW-1:0] d;
    logic [63:0] gap;
    d = due_tbl[id];
    if (d < wheel_now) d = wheel_now;
    due_tbl[id] = d;
    gap = 64'(d - wheel_now);
    if (gap < (64'd1 << WB)) begin
      lvl_tbl[id] = 2'd0; slot_tbl[id] = 8'(d);
    end else if (gap < (64'd1 << 2*WB)) begin
      lvl_tbl[id] = 2'd1; slot_tbl[id] = 8'(d >> WB);
    end else if (gap < (64'd1 << 3*WB)) begin
      lvl_tbl[id] = 2'd2; slot_tbl[id] = 8'(d >> 2*WB);
    end else begin
      // far timers: slot from the clamped due, stored due untouched
      if (gap > FAR_DIST) d = wheel_now + TickW'(FAR_DIST);
      lvl_tbl[id] = 2'd3; slot_tbl[id] = 8'(d >> 3*WB);
    end
    pl_tbl[id] = 1'b1;
  endfunction

  function automatic void recascade(logic [1:0] lv, logic [7:0] sl);
    for (int i = 0; i < NT; i++) begin
      if (pl_tbl[i] && lvl_tbl[i] == lv && slot_tbl[i] == sl) begin
        if (!en_tbl[i]) pl_tbl[i] = 1'b0;
        else place(i);
      end
    end
  endfunction

  function automatic void clear_wheel(logic [TickW-1:0] start);
    for (int i = 0; i < NT; i++) begin
      due_tbl[i] = '0; en_tbl[i] = 1'b0; pl_tbl[i] = 1'b0;
      lvl_tbl[i] = '0; slot_tbl[i] = '0;
    end
    wheel_now = start;
  endfunction

  function automatic out_item_t mk(logic [1:0] st);
    out_item_t r;
    r = '0; r.status = st; r.last = 1'b1;
    return r;
  endfunction

  // Work out the results of one command and queue them.
  function automatic void predict_wheel(in_item_t it);
    logic [TickW-1:0] cur;
    logic [7:0] idx;
    out_item_t r;
    int n;
    n = 0;
    case (it.mode)
      MODE_RESTART: begin
        clear_wheel(it.now_tick + 1'b1);
        pending_results.push_back(mk(ST_OK));
      end
      MODE_ENABLE: begin
        if (en_tbl[it.timer_id]) pending_results.push_back(mk(ST_BUSY));
        else begin
          due_tbl[it.timer_id] = it.due_tick;
          place(it.timer_id);
          en_tbl[it.timer_id] = 1'b1;
          pending_results.push_back(mk(ST_OK));
        end
      end
      MODE_REMOVE: begin
        if (!pl_tbl[it.timer_id]) pending_results.push_back(mk(ST_NOENTRY));
        else begin
          en_tbl[it.timer_id] = 1'b0; pl_tbl[it.timer_id] = 1'b0;
          pending_results.push_back(mk(ST_OK));
        end
      end
      default: begin
        cur = wheel_now;
        if (cur <= it.now_tick) begin
          idx = 8'(cur);
          if (idx == 0) begin
            recascade(2'd1, 8'(cur >> WB));
            if (8'(cur >> WB) == 0) begin
              recascade(2'd2, 8'(cur >> 2*WB));
              if (8'(cur >> 2*WB) == 0) recascade(2'd3, 8'(cur >> 3*WB));
            end
          end
          wheel_now = cur + 1'b1;
          for (int i = 0; i < NT; i++) begin
            if (pl_tbl[i] && lvl_tbl[i] == 0 && slot_tbl[i] == idx) begin
              pl_tbl[i] = 1'b0;
              if (en_tbl[i]) begin
                en_tbl[i] = 1'b0;
                r = '0; r.expired_valid = 1'b1; r.expired_timer = IdW'(i);
                pending_results.push_back(r);
                n++;
              end
            end
          end
        end
        if (n == 0) pending_results.push_back(mk(ST_OK));
        else begin
          r = pending_results.pop_back();
          r.expired_count = CntW'(n); r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 26);
  endfunction

  // Drive one command and wait until it is taken.
  task automatic send_cmd(logic [1:0] m, int id, logic [TickW-1:0] due,
                          logic [TickW-1:0] now);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item_i <= '{mode: m, timer_id: IdW'(id), due_tick: due, now_tick: now};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_wheel('{mode: m, timer_id: IdW'(id), due_tick: due, now_tick: now});
    @(negedge clk_i);
  endtask

  // Output side: random stall, compare at the rising edge.
  always @(negedge clk_i) if (rst_ni) out_ready_i <= !idle_now();

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no command pending: %p", out_item_o);
        errors++;
      end else begin : cmp
        out_item_t e;
        e = pending_results.pop_front();
        if (out_item_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item_o.status); errors++;
        end
        if (out_item_o.expired_valid !== e.expired_valid) begin
          $error("expired_valid exp %0d got %0d", e.expired_valid,
                 out_item_o.expired_valid); errors++;
        end
        if (out_item_o.expired_timer !== e.expired_timer) begin
          $error("expired_timer exp %0d got %0d", e.expired_timer,
                 out_item_o.expired_timer); errors++;
        end
        if (out_item_o.expired_count !== e.expired_count) begin
          $error("expired_count exp %0d got %0d", e.expired_count,
                 out_item_o.expired_count); errors++;
        end
        if (out_item_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_item_o.last); errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Ticks from the wheel tick on, until a given count has run.
  task automatic run_ticks(int cnt);
    for (int k = 0; k < cnt; k++) send_cmd(MODE_TICK, 0, '0, wheel_now);
  endtask

  // Every status, the far clamp, a past due and the expiry order.
  task automatic test_basic_modes();
    send_cmd(MODE_REMOVE, 3, '0, '0);               // no entry
    send_cmd(MODE_ENABLE, 3, '0, '0);               // past due raised
    send_cmd(MODE_ENABLE, 3, 48'd5, '0);            // busy
    send_cmd(MODE_ENABLE, 31, 48'd1, '0);
    send_cmd(MODE_ENABLE, 0, TICK_MAX, '0);         // far, clamped slot
    send_cmd(MODE_ENABLE, 7, 48'd300, '0);          // level 1
    send_cmd(MODE_ENABLE, 8, 48'd70000, '0);        // level 2
    send_cmd(MODE_ENABLE, 9, 48'h20000000, '0);     // level 3
    send_cmd(MODE_TICK, 0, '0, '0);                 // before the wheel tick
    send_cmd(MODE_TICK, 0, '0, TICK_MAX);           // 3 and 31 expire
    send_cmd(MODE_TICK, 0, '0, 48'd2);              // empty tick
    send_cmd(MODE_REMOVE, 0, '0, '0);
    send_cmd(MODE_REMOVE, 0, '0, '0);
    drain();
  endtask

  // Cascades at every level, near the top of the tick range and wrapping.
  task automatic test_cascade_wrap();
    send_cmd(MODE_RESTART, 0, '0, 48'hfe);          // wheel tick 0xff
    send_cmd(MODE_ENABLE, 1, 48'h101, '0);
    send_cmd(MODE_ENABLE, 2, 48'h100, '0);
    send_cmd(MODE_ENABLE, 4, 48'h200, '0);
    send_cmd(MODE_REMOVE, 4, '0, '0);
    run_ticks(3);
    send_cmd(MODE_RESTART, 0, '0, 48'hfffe);
    send_cmd(MODE_ENABLE, 5, 48'h10000, '0);        // level 0, one past the wheel tick
    run_ticks(2);
    send_cmd(MODE_RESTART, 0, '0, TICK_MAX - 1);    // wheel tick at max
    send_cmd(MODE_ENABLE, 6, 48'h5, '0);            // past due -> max
    run_ticks(2);                                   // wraps to zero
    drain();
  endtask

  // All 32 timers at one slot, one tick returns them all.
  task automatic test_full_expiry();
    send_cmd(MODE_RESTART, 0, '0, 48'd9);
    for (int i = NT - 1; i >= 0; i--) send_cmd(MODE_ENABLE, i, 48'd12, '0);
    run_ticks(3);
    drain();
  endtask

  // Random commands: enables with mostly short distances, removes, restarts and ticks that mostly catch up.
  task automatic test_random(int cnt);
    int pick;
    logic [TickW-1:0] due;
    for (int k = 0; k < cnt; k++) begin
      quiet = (k >= cnt / 3 && k < cnt / 2);
      pick = $urandom_range(99);
      if (pick < 3) send_cmd(MODE_RESTART, 0, '0, TickW'({$urandom, $urandom}));
      else if (pick < 45) begin
        case ($urandom_range(5))
          0: due = TickW'({$urandom, $urandom});
          1: due = wheel_now + TickW'($urandom_range(70000));
          2: due = wheel_now - TickW'($urandom_range(5));
          default: due = wheel_now + TickW'($urandom_range(20));
        endcase
        send_cmd(MODE_ENABLE, $urandom_range(NT - 1), due, '0);
      end else if (pick < 55) send_cmd(MODE_REMOVE, $urandom_range(NT - 1), '0, '0);
      else if (pick < 60) send_cmd(MODE_TICK, 0, '0, TickW'({$urandom, $urandom}));
      else send_cmd(MODE_TICK, 0, '0, wheel_now + TickW'($urandom_range(3)));
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    clear_wheel(48'd1);
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_modes();
    test_cascade_wrap();
    test_full_expiry();
    test_random(140);
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/htw_pkg.sv
rtl/core/htw_datapath.sv
rtl/core/htw_ctrl.sv
rtl/core/hierarchical_timer_wheel_top.sv
rtl/core/htw_checker.sv
bench/hierarchical_timer_wheel_top_tb.sv
